>>> rtl/core/vector_plane_projection_assert.svh
// Assertion macros used by the checker of the projection block
`ifndef VECTOR_PLANE_PROJECTION_ASSERT_SVH
`define VECTOR_PLANE_PROJECTION_ASSERT_SVH

// Check that an expression holds at every clock edge out of reset
`define VPP_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle
`define VPP_ASSERT_IMPLY(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/vpp_pkg.sv
// Shared constants and types of the plane projection block
package vpp_pkg;
	localparam int COMPONENT_BITS_DEF = 16;

	// Control that travels with each beat down the pipe
	typedef struct packed {
		logic valid;
		logic degen;
	} vpp_ctl_t;
endpackage

>>> rtl/core/vpp_front.sv
// Front pipe: cross product, dot products and wide numerator for each component
module vpp_front #(
	parameter int C = vpp_pkg::COMPONENT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [C-1:0]   v [3],
	input  logic signed [C-1:0]   a [3],
	input  logic signed [C-1:0]   b [3],
	output vpp_pkg::vpp_ctl_t     ctl_o,
	output logic signed [C-1:0]   v_o [3],
	output logic [4*C+1:0]        nn_o,
	output logic [5*C+3:0]        rem_o [3],
	output logic [2:0]            neg_o
);
	import vpp_pkg::*;

	localparam int NB   = 2*C + 1;
	localparam int DB   = 3*C + 3;
	localparam int NNB  = 4*C + 2;
	localparam int L    = C + 1;
	localparam int NUMB = 5*C + 4;
	localparam int PB   = 2*C;
	localparam int VNB  = 3*C + 1;
	localparam int SQB  = 2*NB;
	localparam int PLB  = DB + L + 1;
	localparam int PHB  = DB + C;

	vpp_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic signed [C-1:0] v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3], v_s5 [3], v_s6 [3], v_s7 [3];
	logic signed [C-1:0] a_s1 [3], b_s1 [3];
	logic signed [2*C-1:0] pr_s2 [6];
	logic signed [NB-1:0] n_s3 [3], n_s4 [3], n_s5 [3];
	logic signed [3*C:0] vn_s4 [3];
	logic signed [2*NB-1:0] sq_s4 [3];
	logic signed [DB-1:0] dot_s5;
	logic [NNB-1:0] nn_s5, nn_s6, nn_s7;
	logic signed [DB+L:0] plo_s6 [3];
	logic signed [DB+C-1:0] phi_s6 [3];
	logic [NUMB-1:0] rem_s7 [3];
	logic [2:0] neg_s7;
	logic signed [NUMB-1:0] num [3];
	logic n_zero, v_zero;

	// Advance control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s1 <= '{valid: in_valid, degen: 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= '{valid: ctl_s2.valid, degen: 1'b0};
			ctl_s4 <= '{valid: ctl_s3.valid, degen: n_zero || v_zero};
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	// Detect a zero normal or a zero vector
	always_comb begin
		n_zero = (n_s3[0] == '0) && (n_s3[1] == '0) && (n_s3[2] == '0);
		v_zero = (v_s3[0] == '0) && (v_s3[1] == '0) && (v_s3[2] == '0);
	end

	// Numerator per component from the split product
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = NUMB'(phi_s6[i]) * (NUMB'(1) <<< L) + NUMB'(plo_s6[i]);
		end
	end

	// Payload pipe
	always_ff @(posedge clk) begin
		v_s1 <= v;
		a_s1 <= a;
		b_s1 <= b;
		v_s2 <= v_s1;
		pr_s2[0] <= PB'(a_s1[1]) * PB'(b_s1[2]);
		pr_s2[1] <= PB'(a_s1[2]) * PB'(b_s1[1]);
		pr_s2[2] <= PB'(a_s1[2]) * PB'(b_s1[0]);
		pr_s2[3] <= PB'(a_s1[0]) * PB'(b_s1[2]);
		pr_s2[4] <= PB'(a_s1[0]) * PB'(b_s1[1]);
		pr_s2[5] <= PB'(a_s1[1]) * PB'(b_s1[0]);
		v_s3 <= v_s2;
		for (int i = 0; i < 3; i++) begin
			n_s3[i] <= NB'(pr_s2[2*i]) - NB'(pr_s2[2*i+1]);
		end
		v_s4 <= v_s3;
		n_s4 <= n_s3;
		for (int i = 0; i < 3; i++) begin
			vn_s4[i] <= VNB'(v_s3[i]) * VNB'(n_s3[i]);
			sq_s4[i] <= SQB'(n_s3[i]) * SQB'(n_s3[i]);
		end
		v_s5 <= v_s4;
		n_s5 <= n_s4;
		dot_s5 <= DB'(vn_s4[0]) + DB'(vn_s4[1]) + DB'(vn_s4[2]);
		nn_s5 <= NNB'(sq_s4[0]) + NNB'(sq_s4[1]) + NNB'(sq_s4[2]);
		v_s6 <= v_s5;
		nn_s6 <= nn_s5;
		for (int i = 0; i < 3; i++) begin
			plo_s6[i] <= PLB'(dot_s5) * PLB'($signed({1'b0, n_s5[i][L-1:0]}));
			phi_s6[i] <= PHB'(dot_s5) * PHB'($signed(n_s5[i][NB-1:L]));
		end
		v_s7 <= v_s6;
		nn_s7 <= nn_s6;
		for (int i = 0; i < 3; i++) begin
			neg_s7[i] <= num[i][NUMB-1];
			rem_s7[i] <= num[i][NUMB-1] ? NUMB'(-num[i]) : NUMB'(num[i]);
		end
	end

	assign ctl_o = ctl_s7;
	assign v_o   = v_s7;
	assign nn_o  = nn_s7;
	assign rem_o = rem_s7;
	assign neg_o = neg_s7;
endmodule

>>> rtl/core/vpp_div_cell.sv
// One quotient-bit cell of the restoring divider chain, three lanes wide
module vpp_div_cell #(
	parameter int C = vpp_pkg::COMPONENT_BITS_DEF,
	parameter int K = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vpp_pkg::vpp_ctl_t     ctl_i,
	input  logic signed [C-1:0]   v_i [3],
	input  logic [4*C+1:0]        nn_i,
	input  logic [5*C+3:0]        rem_i [3],
	input  logic [C:0]            q_i [3],
	input  logic [2:0]            neg_i,
	output vpp_pkg::vpp_ctl_t     ctl_o,
	output logic signed [C-1:0]   v_o [3],
	output logic [4*C+1:0]        nn_o,
	output logic [5*C+3:0]        rem_o [3],
	output logic [C:0]            q_o [3],
	output logic [2:0]            neg_o
);
	import vpp_pkg::*;

	localparam int RB = 5*C + 4;
	localparam int QB = C + 1;

	logic [RB-1:0] d;
	logic [2:0] ge;

	// Compare each remainder with the divisor aligned to this bit
	always_comb begin
		d = RB'(nn_i) << K;
		for (int i = 0; i < 3; i++) begin
			ge[i] = rem_i[i] >= d;
		end
	end

	// Hand control to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	// Subtract where it fits and set the quotient bit
	always_ff @(posedge clk) begin
		v_o   <= v_i;
		nn_o  <= nn_i;
		neg_o <= neg_i;
		for (int i = 0; i < 3; i++) begin
			rem_o[i] <= ge[i] ? rem_i[i] - d : rem_i[i];
			q_o[i]   <= q_i[i] | (QB'(ge[i]) << K);
		end
	end
endmodule

>>> rtl/core/vector_plane_projection.sv
// Top level: projects a 3-D vector onto the plane spanned by two vectors
//
//  channel | ports                              | beat marker
//  --------+------------------------------------+-------------------
//  in      | v_x v_y v_z a_x a_y a_z b_x b_y b_z | start && !busy
//  out     | p_x p_y p_z degenerate             | done
//
// A new beat may enter every cycle; busy stays low.
// The pipe holds seven front-pipe stages, then one divider cell per quotient
// bit, then the output register.
// Reset clears only the control bits of the pipe and the output flags; the receiver cannot stall.
module vector_plane_projection #(
	parameter int COMPONENT_BITS = vpp_pkg::COMPONENT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COMPONENT_BITS-1:0] v_x,
	input  logic signed [COMPONENT_BITS-1:0] v_y,
	input  logic signed [COMPONENT_BITS-1:0] v_z,
	input  logic signed [COMPONENT_BITS-1:0] a_x,
	input  logic signed [COMPONENT_BITS-1:0] a_y,
	input  logic signed [COMPONENT_BITS-1:0] a_z,
	input  logic signed [COMPONENT_BITS-1:0] b_x,
	input  logic signed [COMPONENT_BITS-1:0] b_y,
	input  logic signed [COMPONENT_BITS-1:0] b_z,
	output logic                             done,
	output logic signed [COMPONENT_BITS:0]   p_x,
	output logic signed [COMPONENT_BITS:0]   p_y,
	output logic signed [COMPONENT_BITS:0]   p_z,
	output logic                             degenerate
);
	import vpp_pkg::*;

	localparam int C       = COMPONENT_BITS;
	localparam int QB      = C + 1;

	logic signed [C-1:0] v_in [3], a_in [3], b_in [3];
	vpp_ctl_t            ctl_c [QB+1];
	logic signed [C-1:0] v_c [QB+1][3];
	logic [4*C+1:0]      nn_c [QB+1];
	logic [5*C+3:0]      rem_c [QB+1][3];
	logic [C:0]          q_c [QB+1][3];
	logic [2:0]          neg_c [QB+1];
	logic signed [C+1:0] qs [3];
	logic signed [C:0]   p_d [3];
	logic signed [C:0]   p_q [3];
	logic                done_q, degen_q;

	assign busy = 1'b0;
	assign v_in = '{v_x, v_y, v_z};
	assign a_in = '{a_x, a_y, a_z};
	assign b_in = '{b_x, b_y, b_z};

	vpp_front #(.C(C)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.v        (v_in),
		.a        (a_in),
		.b        (b_in),
		.ctl_o    (ctl_c[0]),
		.v_o      (v_c[0]),
		.nn_o     (nn_c[0]),
		.rem_o    (rem_c[0]),
		.neg_o    (neg_c[0])
	);

	assign q_c[0] = '{default: '0};

	// Divider chain, most significant quotient bit first
	for (genvar k = 0; k < QB; k++) begin : g_cell
		vpp_div_cell #(.C(C), .K(QB - 1 - k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ctl_c[k]),
			.v_i    (v_c[k]),
			.nn_i   (nn_c[k]),
			.rem_i  (rem_c[k]),
			.q_i    (q_c[k]),
			.neg_i  (neg_c[k]),
			.ctl_o  (ctl_c[k+1]),
			.v_o    (v_c[k+1]),
			.nn_o   (nn_c[k+1]),
			.rem_o  (rem_c[k+1]),
			.q_o    (q_c[k+1]),
			.neg_o  (neg_c[k+1])
		);
	end

	// Subtract the signed quotient; zero the result when degenerate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qs[i] = neg_c[QB][i] ? -$signed({1'b0, q_c[QB][i]}) : $signed({1'b0, q_c[QB][i]});
			p_d[i] = ctl_c[QB].degen ? '0 : (C+1)'((C+2)'(v_c[QB][i]) - qs[i]);
		end
	end

	// Output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			degen_q <= 1'b0;
		end else begin
			done_q  <= ctl_c[QB].valid;
			degen_q <= ctl_c[QB].valid && ctl_c[QB].degen;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		p_q <= p_d;
	end

	assign done       = done_q;
	assign degenerate = degen_q;
	assign p_x        = p_q[0];
	assign p_y        = p_q[1];
	assign p_z        = p_q[2];
endmodule

>>> rtl/core/vpp_checker.sv
// Port-level checker for the projection block, bound to the top level
`include "vector_plane_projection_assert.svh"

module vpp_checker #(
	parameter int C = vpp_pkg::COMPONENT_BITS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                busy,
	input logic                done,
	input logic signed [C:0]   p_x,
	input logic signed [C:0]   p_y,
	input logic signed [C:0]   p_z,
	input logic                degenerate
);
	// Stay ready every cycle
	`VPP_ASSERT_ALWAYS(a_never_busy, !busy)
	// Flag only with a result beat
	`VPP_ASSERT_IMPLY(a_degen_with_done, degenerate, done)
	// Zero result on a degenerate beat
	`VPP_ASSERT_IMPLY(a_degen_zero, done && degenerate, p_x == '0 && p_y == '0 && p_z == '0)
endmodule

bind vector_plane_projection vpp_checker #(.C(COMPONENT_BITS)) u_vpp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.busy       (busy),
	.done       (done),
	.p_x        (p_x),
	.p_y        (p_y),
	.p_z        (p_z),
	.degenerate (degenerate)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the vector plane projection block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = vpp_pkg::COMPONENT_BITS_DEF;
	localparam int PIPE_DEPTH = 7 + (CB + 1) + 1;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic signed [CB-1:0] comp_t;
	typedef logic signed [CB:0] proj_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		proj_t px;
		proj_t py;
		proj_t pz;
		logic  degen;
	} projection_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	comp_t v_x, v_y, v_z, a_x, a_y, a_z, b_x, b_y, b_z;
	logic  done;
	proj_t p_x, p_y, p_z;
	logic  degenerate;

	projection_t pending_proj[$];
	int          fail_count;
	int          cycle_count;
	int          idle_pct;

	vector_plane_projection dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.v_x(v_x), .v_y(v_y), .v_z(v_z),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.done(done), .p_x(p_x), .p_y(p_y), .p_z(p_z), .degenerate(degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Project v onto the plane of a and b with exact wide arithmetic
	function automatic projection_t project(input comp_t vv[3], input comp_t aa[3],
			input comp_t bb[3]);
		wide_t v[3], a[3], b[3], n[3];
		wide_t dot, nn, q;
		projection_t r;
		for (int i = 0; i < 3; i++) begin
			v[i] = wide_t'(vv[i]);
			a[i] = wide_t'(aa[i]);
			b[i] = wide_t'(bb[i]);
		end
		n[0] = a[1] * b[2] - a[2] * b[1];
		n[1] = a[2] * b[0] - a[0] * b[2];
		n[2] = a[0] * b[1] - a[1] * b[0];
		r = '{px: '0, py: '0, pz: '0, degen: 1'b1};
		if ((n[0] == 0 && n[1] == 0 && n[2] == 0) || (v[0] == 0 && v[1] == 0 && v[2] == 0))
			return r;
		dot = v[0] * n[0] + v[1] * n[1] + v[2] * n[2];
		nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
		r.degen = 1'b0;
		q = (dot * n[0]) / nn;
		r.px = proj_t'(v[0] - q);
		q = (dot * n[1]) / nn;
		r.py = proj_t'(v[1] - q);
		q = (dot * n[2]) / nn;
		r.pz = proj_t'(v[2] - q);
		return r;
	endfunction

	// Drive one beat, hold it until accepted, then queue its expected projection
	task automatic send_vectors(input comp_t vv[3], input comp_t aa[3], input comp_t bb[3]);
		start <= 1'b1;
		v_x <= vv[0]; v_y <= vv[1]; v_z <= vv[2];
		a_x <= aa[0]; a_y <= aa[1]; a_z <= aa[2];
		b_x <= bb[0]; b_y <= bb[1]; b_z <= bb[2];
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_proj.push_back(project(vv, aa, bb));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
	endtask

	function automatic comp_t rand_comp();
		case ($urandom_range(5))
			0: return comp_t'($urandom_range(7)) - comp_t'(3);
			1: return $urandom_range(1) ? comp_t'(16'sh7fff) : comp_t'(16'sh8000);
			2: return comp_t'($urandom_range(511)) - comp_t'(256);
			default: return comp_t'($urandom);
		endcase
	endfunction

	// Hit the range extremes, zero vectors and parallel spanning vectors
	task automatic test_directed();
		comp_t mx, mn;
		mx = 16'sh7fff;
		mn = 16'sh8000;
		idle_pct = 0;
		send_vectors('{1, 2, 3}, '{1, 0, 0}, '{0, 1, 0});
		send_vectors('{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0});
		send_vectors('{5, 6, 7}, '{0, 0, 0}, '{0, 1, 0});
		send_vectors('{5, 6, 7}, '{2, 4, 6}, '{1, 2, 3});
		send_vectors('{5, 6, 7}, '{3, -1, 2}, '{-6, 2, -4});
		send_vectors('{mx, mx, mx}, '{mx, mn, 0}, '{mn, mx, mx});
		send_vectors('{mn, mn, mn}, '{mn, mx, mn}, '{mx, mn, mn});
		send_vectors('{mx, mn, mx}, '{mn, 0, mx}, '{0, mn, 1});
		send_vectors('{mn, mx, mn}, '{mn, mn, mn}, '{mn, mn, mx});
		send_vectors('{mx, mx, mx}, '{1, 1, 0}, '{-1, 1, 1});
		send_vectors('{-1, -1, -1}, '{mx, 0, 0}, '{0, 0, mn});
		send_vectors('{3, -4, 5}, '{1, 1, 1}, '{1, -1, 0});
		send_vectors('{mn, mn, mn}, '{mn, mn, mn}, '{mn, mn, mn});
		send_vectors('{0, 0, 1}, '{mx, mx, mx}, '{mx, mx, mn});
	endtask

	// Send random beats, biased toward small values, extremes, zero vectors and parallel spanning vectors
	task automatic test_random(input int count, input int pct);
		comp_t vv[3], aa[3], bb[3];
		int k;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			for (int j = 0; j < 3; j++) begin
				vv[j] = rand_comp();
				aa[j] = rand_comp();
				bb[j] = rand_comp();
			end
			k = $urandom_range(19);
			if (k == 0)
				vv = '{0, 0, 0};
			else if (k == 1)
				bb = aa;
			else if (k == 2)
				for (int j = 0; j < 3; j++) bb[j] = -aa[j];
			else if (k == 3)
				for (int j = 0; j < 3; j++) bb[j] = aa[j] >>> 1;
			send_vectors(vv, aa, bb);
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Hold off until the pipe has drained completely
	task automatic test_drain_pause();
		start <= 1'b0;
		@(posedge clk);
		while (pending_proj.size() != 0) @(posedge clk);
	endtask

	// Compare each result beat against the oldest expected projection
	always @(posedge clk) begin
		projection_t e;
		if (arst_n && done) begin
			if (pending_proj.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = pending_proj.pop_front();
				if (p_x !== e.px) begin
					$error("p_x expected %0d actual %0d", e.px, p_x);
					fail_count++;
				end
				if (p_y !== e.py) begin
					$error("p_y expected %0d actual %0d", e.py, p_y);
					fail_count++;
				end
				if (p_z !== e.pz) begin
					$error("p_z expected %0d actual %0d", e.pz, p_z);
					fail_count++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate expected %0d actual %0d", e.degen, degenerate);
					fail_count++;
				end
			end
		end
	end

	// Abort a run that stops making progress
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		cycle_count = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{v_x, v_y, v_z, a_x, a_y, a_z, b_x, b_y, b_z} = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(230, 36);
		test_drain_pause();
		test_random(230, 81);
		test_random(240, 0);
		while (pending_proj.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 5) @(posedge clk);
		if (fail_count == 0 && pending_proj.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/vpp_pkg.sv
rtl/core/vpp_front.sv
rtl/core/vpp_div_cell.sv
rtl/core/vector_plane_projection.sv
rtl/core/vpp_checker.sv
tb/sv/testbench.sv
